@@ hdl/axlp_pkg.sv @@
// axlp_pkg: shared types and character codes for the x/y line parser
`default_nettype none
package axlp_pkg;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int VAL_W = 16;

	typedef enum logic [11:0] {
		PH_X      = 12'b0000_0000_0001,
		PH_XCOLON = 12'b0000_0000_0010,
		PH_XLEAD  = 12'b0000_0000_0100,
		PH_XSIGN  = 12'b0000_0000_1000,
		PH_XDIG   = 12'b0000_0001_0000,
		PH_Y      = 12'b0000_0010_0000,
		PH_YCOLON = 12'b0000_0100_0000,
		PH_YLEAD  = 12'b0000_1000_0000,
		PH_YSIGN  = 12'b0001_0000_0000,
		PH_YDIG   = 12'b0010_0000_0000,
		PH_DONE   = 12'b0100_0000_0000,
		PH_FAIL   = 12'b1000_0000_0000
	} phase_t;

	// what the parser hands to the output stage for one line
	typedef struct packed {
		logic              hit;
		logic [VAL_W-1:0]  x;
		logic [VAL_W-1:0]  y;
	} parse_res_t;

endpackage
`default_nettype wire

@@ hdl/ascii_xy_line_parser.sv @@
// ascii_xy_line_parser: top level, input register, parser and result register
//
//  channel | handshake           | payload
//  --------+---------------------+---------------------------------
//  in      | in_valid / in_stall | rx_byte [7:0]
//  out     | out_valid/out_stall | x_value [15:0], y_value [15:0] signed
//
// one byte per cycle, back to back while in_stall is low; an accepted byte is held
// in the input register until the parser advances; the parser state and the result
// register then update from it; a newline's result lands in the result register.
// arst_n returns the parser to an empty line waiting for X.
// out_stall holds the result and freezes the parser; the input register then takes
// one more byte and raises in_stall until the result moves on.
`default_nettype none
module ascii_xy_line_parser #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      x_value,
	output logic signed [15:0]      y_value
);
	import axlp_pkg::*;

	logic             valid_s1, valid_s2;
	logic [7:0]       byte_s1;
	logic [VAL_W-1:0] x_s2, y_s2;
	logic             adv, take;
	parse_res_t       res;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	axlp_parse #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (valid_s1 && adv),
		.rx_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) valid_s2 <= res.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (take) byte_s1 <= rx_byte;
		if (adv && res.hit) begin
			x_s2 <= res.x;
			y_s2 <= res.y;
		end
	end

	assign out_valid = valid_s2;
	assign x_value   = signed'(x_s2);
	assign y_value   = signed'(y_s2);

endmodule
`default_nettype wire

@@ hdl/axlp_parse.sv @@
// axlp_parse: line state, field accumulators and per-byte next-state logic
`default_nettype none
module axlp_parse #(
	parameter int LINE_CAPACITY = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [7:0]          rx_byte,
	output axlp_pkg::parse_res_t     res
);
	import axlp_pkg::*;

	localparam int CW = $clog2(LINE_CAPACITY);
	localparam logic [CW-1:0] CNT_LAST = CW'(LINE_CAPACITY - 1);

	phase_t           phase_q, phase_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic [VAL_W-1:0] xacc_q, xacc_d, yacc_q, yacc_d;
	logic             xneg_q, xneg_d, yneg_q, yneg_d;

	logic             blank, digit, y_seen;
	logic [VAL_W-1:0] xpush, ypush;

	assign blank  = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
	                (rx_byte == CH_VT) || (rx_byte == CH_FF);
	assign digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
	assign y_seen = (phase_q == PH_YDIG) || (phase_q == PH_DONE);

	// acc*10 + digit, wraps at 16 bits
	assign xpush = (xacc_q << 3) + (xacc_q << 1) + {{(VAL_W-4){1'b0}}, rx_byte[3:0]};
	assign ypush = (yacc_q << 3) + (yacc_q << 1) + {{(VAL_W-4){1'b0}}, rx_byte[3:0]};

	assign res.hit = en && (rx_byte == CH_LF) && y_seen;
	assign res.x   = xneg_q ? (VAL_W'(0) - xacc_q) : xacc_q;
	assign res.y   = yneg_q ? (VAL_W'(0) - yacc_q) : yacc_q;

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		xacc_d  = xacc_q;
		yacc_d  = yacc_q;
		xneg_d  = xneg_q;
		yneg_d  = yneg_q;
		if (en && rx_byte != CH_CR) begin
			if (rx_byte == CH_LF || cnt_q >= CNT_LAST) begin
				// end of line or overflow: start over, byte not kept
				phase_d = PH_X;
				cnt_d   = '0;
				xacc_d  = '0;
				yacc_d  = '0;
				xneg_d  = 1'b0;
				yneg_d  = 1'b0;
			end else if (rx_byte == CH_NUL) begin
				cnt_d   = cnt_q + 1'b1;
				phase_d = y_seen ? PH_DONE : PH_FAIL;
			end else begin
				cnt_d   = cnt_q + 1'b1;
				phase_d = PH_FAIL;
				case (phase_q)
					PH_X: begin
						if (rx_byte == CH_X) phase_d = PH_XCOLON;
					end
					PH_XCOLON: begin
						if (rx_byte == CH_COLON) phase_d = PH_XLEAD;
					end
					PH_XLEAD: begin
						if (blank) phase_d = PH_XLEAD;
						else if (rx_byte == CH_PLUS) phase_d = PH_XSIGN;
						else if (rx_byte == CH_MINUS) begin
							xneg_d  = 1'b1;
							phase_d = PH_XSIGN;
						end else if (digit) begin
							xacc_d  = xpush;
							phase_d = PH_XDIG;
						end
					end
					PH_XSIGN: begin
						if (digit) begin
							xacc_d  = xpush;
							phase_d = PH_XDIG;
						end
					end
					PH_XDIG: begin
						if (digit) begin
							xacc_d  = xpush;
							phase_d = PH_XDIG;
						end else if (rx_byte == CH_COMMA) phase_d = PH_Y;
					end
					PH_Y: begin
						if (rx_byte == CH_Y) phase_d = PH_YCOLON;
					end
					PH_YCOLON: begin
						if (rx_byte == CH_COLON) phase_d = PH_YLEAD;
					end
					PH_YLEAD: begin
						if (blank) phase_d = PH_YLEAD;
						else if (rx_byte == CH_PLUS) phase_d = PH_YSIGN;
						else if (rx_byte == CH_MINUS) begin
							yneg_d  = 1'b1;
							phase_d = PH_YSIGN;
						end else if (digit) begin
							yacc_d  = ypush;
							phase_d = PH_YDIG;
						end
					end
					PH_YSIGN: begin
						if (digit) begin
							yacc_d  = ypush;
							phase_d = PH_YDIG;
						end
					end
					PH_YDIG: begin
						if (digit) begin
							yacc_d  = ypush;
							phase_d = PH_YDIG;
						end else phase_d = PH_DONE;
					end
					PH_DONE: begin
						phase_d = PH_DONE;
					end
					default: begin
						phase_d = PH_FAIL;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_X;
			cnt_q   <= '0;
			xacc_q  <= '0;
			yacc_q  <= '0;
			xneg_q  <= 1'b0;
			yneg_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			xacc_q  <= xacc_d;
			yacc_q  <= yacc_d;
			xneg_q  <= xneg_d;
			yneg_q  <= yneg_d;
		end
	end

endmodule
`default_nettype wire
